// ===== rtl/sym2x2_eigen_decompose_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SYM2X2_EIGEN_DECOMPOSE_MACROS_SVH
`define SYM2X2_EIGEN_DECOMPOSE_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define SED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
package sed_pkg;

  localparam int unsigned RemW  = 72;  // radicand / dividend width
  localparam int unsigned RootW = 36;  // square root width
  localparam int unsigned QuoW  = 31;  // quotient width, Q1.30 magnitude

  typedef struct packed {
    logic             valid;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic             valid;
    logic [RootW-1:0] den;
    logic [RemW-1:0]  rem_x;
    logic [RemW-1:0]  rem_y;
    logic [QuoW-1:0]  quo_x;
    logic [QuoW-1:0]  quo_y;
  } div_t;

  // sideband through the first root chain
  typedef struct packed {
    logic [32:0] apc;    // xx + yy
    logic [32:0] cma;    // yy - xx
    logic [32:0] bmag2;  // 2*|xy|
    logic        bneg;
    logic [65:0] bsq;    // bmag2^2
  } side1_t;

  // sideband through the second root chain
  typedef struct packed {
    logic [31:0] eig_l;
    logic [31:0] eig_s;
    logic [34:0] u;
    logic [32:0] bmag2;
    logic        bneg;
    logic        fb;
  } side2_t;

  // sideband through the divider chain
  typedef struct packed {
    logic [31:0] eig_l;
    logic [31:0] eig_s;
    logic        bneg;
    logic        fb;
  } side3_t;

  localparam logic [31:0] AxisOne = 32'h4000_0000;

  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if ((&v[36:31]) || !(|v[36:31])) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sed_sqrt_cell.sv =====
// One bit of a restoring square root.
module sed_sqrt_cell #(
  parameter int unsigned Bit   = 0,
  parameter int unsigned SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sed_pkg::sqrt_t     in_i,
  input  logic [SideW-1:0]   side_i,
  output sed_pkg::sqrt_t     out_o,
  output logic [SideW-1:0]   side_o
);

  logic                        valid_q;
  logic [sed_pkg::RemW-1:0]    rem_d, rem_q, trial;
  logic [sed_pkg::RootW-1:0]   root_d, root_q;
  logic [SideW-1:0]            side_q;
  logic                        take;

  always_comb begin
    trial  = ({{(sed_pkg::RemW-sed_pkg::RootW){1'b0}}, in_i.root} << (Bit + 1))
           | ({{(sed_pkg::RemW-1){1'b0}}, 1'b1} << (2 * Bit));
    take   = trial <= in_i.rem;
    rem_d  = take ? in_i.rem - trial : in_i.rem;
    root_d = in_i.root | (take ? ({{(sed_pkg::RootW-1){1'b0}}, 1'b1} << Bit)
                               : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.rem   = rem_q;
  assign out_o.root  = root_q;
  assign side_o      = side_q;

endmodule

// ===== rtl/sed_div_cell.sv =====
// One quotient bit of two restoring divisions sharing a divisor.
module sed_div_cell #(
  parameter int unsigned Bit   = 0,
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  sed_pkg::div_t     in_i,
  input  logic [SideW-1:0]  side_i,
  output sed_pkg::div_t     out_o,
  output logic [SideW-1:0]  side_o
);

  logic                      valid_q;
  logic [sed_pkg::RemW-1:0]  trial;
  logic                      take_x, take_y;
  logic [sed_pkg::QuoW-1:0]  one_hot;
  sed_pkg::div_t             dat_d, dat_q;
  logic [SideW-1:0]          side_q;

  always_comb begin
    trial   = {{(sed_pkg::RemW-sed_pkg::RootW){1'b0}}, in_i.den} << Bit;
    one_hot = {{(sed_pkg::QuoW-1){1'b0}}, 1'b1} << Bit;
    take_x  = trial <= in_i.rem_x;
    take_y  = trial <= in_i.rem_y;
    dat_d       = in_i;
    dat_d.rem_x = take_x ? in_i.rem_x - trial : in_i.rem_x;
    dat_d.rem_y = take_y ? in_i.rem_y - trial : in_i.rem_y;
    dat_d.quo_x = in_i.quo_x | (take_x ? one_hot : '0);
    dat_d.quo_y = in_i.quo_y | (take_y ? one_hot : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q  <= dat_d;
      side_q <= side_i;
    end
  end

  always_comb begin
    out_o       = dat_q;
    out_o.valid = valid_q;
  end
  assign side_o = side_q;

endmodule

// ===== rtl/sym2x2_eigen_decompose.sv =====
// Symmetric 2x2 eigen decomposition, fully pipelined.
//
// Input stream (s_axis_*): one matrix per item, entries signed Q16.16.
// Output stream (m_axis_*): both eigenvalues (saturated Q16.16), the unit
// eigenvector of the larger eigenvalue in Q1.30, and a fallback flag in tuser
// set when that vector is too short and (1,0) is returned instead.
// Config: cfg_we_i writes cfg_wdata_i to the short-length threshold (Q16.16
// length, reset value 1). Write it only while the pipeline is empty.
//
// Throughput: one item per cycle while the output is not stalled. From
// accept to the output register an item passes two 36-cell square-root
// chains (one root bit per cell) and a 31-cell divider chain (one quotient
// bit per cell), plus eight setup and output stages.
// Reset clears all valid bits; nothing in flight survives it.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken, so s_axis_tready_o drops in the cycle the receiver holds
// m_axis_tready_i low on a full output register, and nothing is lost.
module sym2x2_eigen_decompose (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [95:0]   s_axis_tdata_i,   // weight_xx, weight_xy, weight_yy
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [127:0]  m_axis_tdata_o,   // eigen_large, eigen_small, axis_x, axis_y
  output logic [0:0]    m_axis_tuser_o    // used_fallback
);

  localparam int unsigned NRoot = sed_pkg::RootW;
  localparam int unsigned NQuo  = sed_pkg::QuoW;

  logic        adv;
  logic [15:0] thr_q;

  // global advance: output register free or draining
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd1;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---- stage 1: sums, differences, magnitudes
  logic [31:0] a, b, c, bmag;
  logic [32:0] apc_d, cma_d, dmag_d, bmag2_d;
  logic        v1_q;
  logic [32:0] apc1_q, cma1_q, dmag1_q, bmag21_q;
  logic        bneg1_q;

  always_comb begin
    a       = s_axis_tdata_i[31:0];
    b       = s_axis_tdata_i[63:32];
    c       = s_axis_tdata_i[95:64];
    apc_d   = {a[31], a} + {c[31], c};
    cma_d   = {c[31], c} - {a[31], a};
    dmag_d  = cma_d[32] ? 33'd0 - cma_d : cma_d;
    bmag    = b[31] ? 32'd0 - b : b;
    bmag2_d = {bmag, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      apc1_q   <= apc_d;
      cma1_q   <= cma_d;
      dmag1_q  <= dmag_d;
      bmag21_q <= bmag2_d;
      bneg1_q  <= b[31];
    end
  end

  // ---- stage 2: squares
  logic        v2_q;
  logic [65:0] dsq2_q, bsq2_q;
  logic [32:0] apc2_q, cma2_q, bmag22_q;
  logic        bneg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsq2_q   <= 66'(dmag1_q) * 66'(dmag1_q);
      bsq2_q   <= 66'(bmag21_q) * 66'(bmag21_q);
      apc2_q   <= apc1_q;
      cma2_q   <= cma1_q;
      bmag22_q <= bmag21_q;
      bneg2_q  <= bneg1_q;
    end
  end

  // ---- stage 3: discriminant into first root chain
  sed_pkg::sqrt_t  sq1 [0:NRoot];
  sed_pkg::side1_t sd1 [0:NRoot];
  logic            v3_q;
  logic [66:0]     disc3_q;
  sed_pkg::side1_t side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      disc3_q       <= {1'b0, dsq2_q} + {1'b0, bsq2_q};
      side3_q.apc   <= apc2_q;
      side3_q.cma   <= cma2_q;
      side3_q.bmag2 <= bmag22_q;
      side3_q.bneg  <= bneg2_q;
      side3_q.bsq   <= bsq2_q;
    end
  end

  always_comb begin
    sq1[0].valid = v3_q;
    sq1[0].rem   = {{(sed_pkg::RemW-67){1'b0}}, disc3_q};
    sq1[0].root  = '0;
    sd1[0]       = side3_q;
  end

  for (genvar i = 0; i < NRoot; i++) begin : g_root1
    sed_sqrt_cell #(
      .Bit  (NRoot - 1 - i),
      .SideW($bits(sed_pkg::side1_t))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (sq1[i]),
      .side_i(sd1[i]),
      .out_o (sq1[i+1]),
      .side_o(sd1[i+1])
    );
  end

  // ---- stage 4: eigenvalues and vector y term
  sed_pkg::side1_t s1o;
  logic [37:0]     sext_apc, sext_cma, s_ext, sum_l, sum_s, u_sum;
  logic            v4_q;
  logic [31:0]     eigl4_q, eigs4_q;
  logic [34:0]     u4_q;
  logic [32:0]     bmag24_q;
  logic            bneg4_q;
  logic [65:0]     bsq4_q;

  always_comb begin
    s1o      = sd1[NRoot];
    sext_apc = {{5{s1o.apc[32]}}, s1o.apc};
    sext_cma = {{5{s1o.cma[32]}}, s1o.cma};
    s_ext    = {2'b00, sq1[NRoot].root};
    sum_l    = sext_apc + s_ext;
    sum_s    = sext_apc - s_ext;
    u_sum    = sext_cma + s_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sq1[NRoot].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eigl4_q  <= sed_pkg::sat32(sum_l[37:1]);  // floor halving
      eigs4_q  <= sed_pkg::sat32(sum_s[37:1]);
      u4_q     <= u_sum[34:0];
      bmag24_q <= s1o.bmag2;
      bneg4_q  <= s1o.bneg;
      bsq4_q   <= s1o.bsq;
    end
  end

  // ---- stage 5: u squared, threshold squared
  logic        v5_q;
  logic [69:0] usq5_q;
  logic [33:0] lim5_q;
  logic [16:0] thr2;
  logic [31:0] eigl5_q, eigs5_q;
  logic [34:0] u5_q;
  logic [32:0] bmag25_q;
  logic        bneg5_q;
  logic [65:0] bsq5_q;

  assign thr2 = {thr_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      usq5_q   <= 70'(u4_q) * 70'(u4_q);
      lim5_q   <= 34'(thr2) * 34'(thr2);
      eigl5_q  <= eigl4_q;
      eigs5_q  <= eigs4_q;
      u5_q     <= u4_q;
      bmag25_q <= bmag24_q;
      bneg5_q  <= bneg4_q;
      bsq5_q   <= bsq4_q;
    end
  end

  // ---- stage 6: vector length squared, short-vector test
  sed_pkg::sqrt_t  sq2 [0:NRoot];
  sed_pkg::side2_t sd2 [0:NRoot];
  logic [70:0]     nsum;
  logic            v6_q;
  logic [70:0]     n6_q;
  sed_pkg::side2_t side6_q;

  assign nsum = {1'b0, usq5_q} + {5'd0, bsq5_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n6_q          <= nsum;
      side6_q.eig_l <= eigl5_q;
      side6_q.eig_s <= eigs5_q;
      side6_q.u     <= u5_q;
      side6_q.bmag2 <= bmag25_q;
      side6_q.bneg  <= bneg5_q;
      side6_q.fb    <= nsum <= {37'd0, lim5_q};
    end
  end

  always_comb begin
    sq2[0].valid = v6_q;
    sq2[0].rem   = {{(sed_pkg::RemW-71){1'b0}}, n6_q};
    sq2[0].root  = '0;
    sd2[0]       = side6_q;
  end

  for (genvar i = 0; i < NRoot; i++) begin : g_root2
    sed_sqrt_cell #(
      .Bit  (NRoot - 1 - i),
      .SideW($bits(sed_pkg::side2_t))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (sq2[i]),
      .side_i(sd2[i]),
      .out_o (sq2[i+1]),
      .side_o(sd2[i+1])
    );
  end

  // ---- stage 7: rounded dividends into divider chain
  sed_pkg::side2_t s2o;
  sed_pkg::div_t   dv [0:NQuo];
  sed_pkg::side3_t sd3 [0:NQuo];
  logic [sed_pkg::RemW-1:0] half_root;
  sed_pkg::div_t   div7_q;
  logic            v7_q;
  sed_pkg::side3_t side7_q;

  assign s2o       = sd2[NRoot];
  assign half_root = {{(sed_pkg::RemW-sed_pkg::RootW+1){1'b0}},
                      sq2[NRoot].root[sed_pkg::RootW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= sq2[NRoot].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div7_q.valid <= 1'b0;
      div7_q.den   <= sq2[NRoot].root;
      div7_q.rem_x <= ({{(sed_pkg::RemW-33){1'b0}}, s2o.bmag2} << 30) + half_root;
      div7_q.rem_y <= ({{(sed_pkg::RemW-35){1'b0}}, s2o.u} << 30) + half_root;
      div7_q.quo_x <= '0;
      div7_q.quo_y <= '0;
      side7_q.eig_l <= s2o.eig_l;
      side7_q.eig_s <= s2o.eig_s;
      side7_q.bneg  <= s2o.bneg;
      side7_q.fb    <= s2o.fb;
    end
  end

  always_comb begin
    dv[0]       = div7_q;
    dv[0].valid = v7_q;
    sd3[0]      = side7_q;
  end

  for (genvar i = 0; i < NQuo; i++) begin : g_div
    sed_div_cell #(
      .Bit  (NQuo - 1 - i),
      .SideW($bits(sed_pkg::side3_t))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (dv[i]),
      .side_i(sd3[i]),
      .out_o (dv[i+1]),
      .side_o(sd3[i+1])
    );
  end

  // ---- output register
  sed_pkg::side3_t s3o;
  logic [31:0]     mx, ax_d, ay_d;
  logic            m_valid_q;
  logic [127:0]    m_data_q;
  logic            m_fb_q;

  always_comb begin
    s3o = sd3[NQuo];
    mx  = {1'b0, dv[NQuo].quo_x};
    if (s3o.fb) begin
      ax_d = sed_pkg::AxisOne;
      ay_d = '0;
    end else begin
      ax_d = s3o.bneg ? 32'd0 - mx : mx;
      ay_d = {1'b0, dv[NQuo].quo_y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= dv[NQuo].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {ay_d, ax_d, s3o.eig_s, s3o.eig_l};
      m_fb_q   <= s3o.fb;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_fb_q;

endmodule

// ===== rtl/sed_checker.sv =====
`include "sym2x2_eigen_decompose_macros.svh"

module sed_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_we_i,
  input logic [15:0]   cfg_wdata_i,
  input logic          s_axis_tvalid_i,
  input logic          s_axis_tready_o,
  input logic [95:0]   s_axis_tdata_i,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [127:0]  m_axis_tdata_o,
  input logic [0:0]    m_axis_tuser_o
);

  // a held result keeps its payload
  `SED_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "output changed while stalled")

  // an empty output stage never blocks the input
  `SED_ASSERT_ALWAYS(a_ready_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input blocked with empty output")

  // eigenvalues come out ordered
  `SED_ASSERT(a_order, m_axis_tvalid_o |-> $signed(m_axis_tdata_o[31:0]) >= $signed(m_axis_tdata_o[63:32]), "eigenvalues out of order")

  // fallback vector is exactly (1,0)
  `SED_ASSERT(a_fallback, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[95:64] == 32'h4000_0000 && m_axis_tdata_o[127:96] == 32'd0, "bad fallback vector")

  // y component is never negative
  `SED_ASSERT(a_y_sign, m_axis_tvalid_o |-> !m_axis_tdata_o[127], "negative axis_y")

endmodule

bind sym2x2_eigen_decompose sed_checker u_sed_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] yy;
    logic [31:0] xy;
    logic [31:0] xx;
  } matrix_t;

  typedef struct packed {
    logic        fb;
    logic [31:0] ay;
    logic [31:0] ax;
    logic [31:0] es;
    logic [31:0] el;
  } eigen_t;

  localparam int unsigned Latency = 111;
  localparam longint LimitCycles = 400000;
  localparam logic [31:0] AxisUnit = 32'h4000_0000;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [15:0]   cfg_wdata_i;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [95:0]   s_axis_tdata_i;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [127:0]  m_axis_tdata_o;
  logic [0:0]    m_axis_tuser_o;

  sym2x2_eigen_decompose i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  matrix_t   matrix_q[$];
  eigen_t    eigen_q[$];
  logic [15:0] short_thresh;
  int        n_errors;
  longint    cycle_cnt;
  bit        hold_feed;
  int        src_wait;
  int        snk_wait;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // floor sqrt of a value below 2^72
  function automatic logic [35:0] root72(input logic [71:0] n);
    logic [35:0] r;
    logic [35:0] t;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      if (72'(t) * 72'(t) <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'h7fff_ffff;
    if (v < -40'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Expected decomposition of one matrix under the current threshold.
  function automatic eigen_t decompose(input matrix_t m);
    logic signed [39:0] a, b, c, s, sum;
    logic [39:0]  dmag, bm2;
    logic [71:0]  disc, nrm, lim;
    logic [39:0]  u;
    logic [35:0]  q;
    logic [71:0]  mx, my;
    eigen_t e;
    a = 40'(signed'(m.xx));
    b = 40'(signed'(m.xy));
    c = 40'(signed'(m.yy));
    dmag = (a - c < 0) ? c - a : a - c;
    bm2 = (b < 0) ? -2 * b : 2 * b;
    disc = 72'(dmag) * 72'(dmag) + 72'(bm2) * 72'(bm2);
    s = 40'(root72(disc));
    u = c - a + s;
    nrm = 72'(bm2) * 72'(bm2) + 72'(u) * 72'(u);
    lim = 72'({short_thresh, 1'b0}) * 72'({short_thresh, 1'b0});
    sum = a + c + s;
    e.el = clamp32(sum >>> 1);
    sum = a + c - s;
    e.es = clamp32(sum >>> 1);
    if (nrm <= lim) begin
      e.ax = AxisUnit;
      e.ay = '0;
      e.fb = 1'b1;
    end else begin
      q = root72(nrm);
      mx = ((72'(bm2) << 30) + 72'(q / 2)) / 72'(q);
      my = ((72'(u) << 30) + 72'(q / 2)) / 72'(q);
      e.ax = (b < 0) ? -mx[31:0] : mx[31:0];
      e.ay = my[31:0];
      e.fb = 1'b0;
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  // Driver: feeds queued matrices with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_wait        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        eigen_q.push_back(decompose(matrix_t'(s_axis_tdata_i)));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_wait > 0) begin
          src_wait        <= src_wait - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (matrix_q.size() > 0 && !hold_feed) begin
          s_axis_tdata_i  <= matrix_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          src_wait        <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compares each result with the oldest one due.
  always @(posedge clk_i or negedge rst_ni) begin
    eigen_t got;
    eigen_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      snk_wait        <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o};
        if (eigen_q.size() == 0) begin
          report_mismatch("unexpected result", got.el, 32'd0);
        end else begin
          want = eigen_q.pop_front();
          if (got.el !== want.el) report_mismatch("eigen_large", got.el, want.el);
          if (got.es !== want.es) report_mismatch("eigen_small", got.es, want.es);
          if (got.ax !== want.ax) report_mismatch("axis_x", got.ax, want.ax);
          if (got.ay !== want.ay) report_mismatch("axis_y", got.ay, want.ay);
          if (got.fb !== want.fb) report_mismatch("used_fallback", 32'(got.fb), 32'(want.fb));
        end
      end
      if (snk_wait > 0) begin
        snk_wait        <= snk_wait - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (m_axis_tvalid_o && $urandom_range(0, 4) == 0) snk_wait <= $urandom_range(0, 17);
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      3: return 32'($urandom_range(0, 4)) - 32'd2;
      4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(0, 65536 * 4));
    endcase
  endfunction

  task automatic queue_random(input int count);
    matrix_t m;
    for (int k = 0; k < count; k++) begin
      m.xx = rand_entry();
      m.xy = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_entry();
      m.yy = ($urandom_range(0, 7) == 0) ? m.xx : rand_entry();
      matrix_q.push_back(m);
    end
  endtask

  // Waits until everything fed has come back, then lets the pipeline drain.
  task automatic drain();
    while (matrix_q.size() > 0 || s_axis_tvalid_i || eigen_q.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    short_thresh = val;
  endtask

  initial begin
    logic [15:0] thr_set[4];
    n_errors = 0;
    cycle_cnt = 0;
    hold_feed = 1'b0;
    short_thresh = 16'd1;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero matrix, diagonal, equal diagonal, tiny vectors
    matrix_q.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    matrix_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    matrix_q.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
    matrix_q.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
    matrix_q.push_back('{32'd0, 32'd0, 32'd0});
    matrix_q.push_back('{32'h0001_0000, 32'd0, 32'h0003_0000});
    matrix_q.push_back('{32'h0003_0000, 32'd0, 32'h0001_0000});
    matrix_q.push_back('{32'h0002_0000, 32'h0001_0000, 32'h0002_0000});
    matrix_q.push_back('{32'h0002_0000, 32'hffff_0000, 32'h0002_0000});
    matrix_q.push_back('{32'd0, 32'd1, 32'd0});
    matrix_q.push_back('{32'd1, 32'd0, 32'd0});
    matrix_q.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'd0});
    matrix_q.push_back('{32'h7fff_ffff, 32'd0, 32'h8000_0000});
    matrix_q.push_back('{32'h8000_0000, 32'd0, 32'h7fff_ffff});
    matrix_q.push_back('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
    matrix_q.push_back('{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
    drain();

    thr_set[0] = 16'hffff;
    thr_set[1] = 16'd0;
    thr_set[2] = 16'h0100;
    thr_set[3] = 16'd1;
    for (int p = 0; p < 4; p++) begin
      write_threshold(thr_set[p]);
      queue_random(175);
      if (p == 1) begin
        // hold the sender off until the pipeline is empty, then resume
        while (matrix_q.size() > 85) @(posedge clk_i);
        hold_feed = 1'b1;
        while (s_axis_tvalid_i || eigen_q.size() > 0) @(posedge clk_i);
        hold_feed = 1'b0;
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
